@@ sv/rycc_pkg.sv @@
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int SizeW     = 13;
	localparam int FifoDepth = 4;
	localparam int FifoAw    = $clog2(FifoDepth);

	localparam logic [SizeW-1:0] WidthReset  = 13'd640;
	localparam logic [SizeW-1:0] HeightReset = 13'd480;

	localparam logic RegImageWidth  = 1'b0;
	localparam logic RegImageHeight = 1'b1;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		logic frame_end;
		logic chroma_valid;
		rgb_t mean;
		rgb_t pixel;
	} entry_t;

endpackage

@@ sv/rgb_to_ycbcr_420_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_420_converter
// RGB pixel stream in raster order to per-pixel luma with 4:2:0 chroma.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per transaction, red/green/blue in tdata.
//   m_axis returns one transaction per pixel: luma, Cb, Cr in tdata,
//   chroma_valid in tuser (set on the pixel that completes a 2x2 quad),
//   tlast on the last pixel of the frame. Cb and Cr read zero otherwise.
//   cfg_write with cfg_index 0 sets the image width, 1 the image height;
//   write only while the block is idle. Zero counts as one, sizes above
//   4096 saturate.
//   Throughput is one pixel per clock while m_axis does not stall. An accepted
//   pixel passes through the front stage that reads the line store, the
//   queue, and the multiply and saturate stages of the back, in that order.
//   A stall on m_axis freezes the back end; the four-entry queue and the
//   front stage keep taking pixels until the queue fills.
//   Reset clears position counters and the queue and loads 640 x 480.
//   The line store needs no clearing: an odd row only reads entries the
//   even row above it wrote.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_420_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red, green, blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // luma, blue_diff, red_diff
	output logic        m_axis_tuser,  // chroma_valid
	output logic        m_axis_tlast   // frame_end
);
	import rycc_pkg::*;

	rgb_t       in_pixel;
	entry_t     push_entry, pop_entry;
	logic       push, pop, fifo_full, fifo_empty;
	logic [7:0] luma, blue_diff, red_diff;

	assign in_pixel.red   = s_axis_tdata[7:0];
	assign in_pixel.green = s_axis_tdata[15:8];
	assign in_pixel.blue  = s_axis_tdata[23:16];
	assign m_axis_tdata   = {red_diff, blue_diff, luma};

	rycc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_pixel   (in_pixel),
		.push       (push),
		.push_entry (push_entry),
		.fifo_full  (fifo_full)
	);

	rycc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.empty      (fifo_empty),
		.pop_entry  (pop_entry)
	);

	rycc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (fifo_empty),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.luma         (luma),
		.blue_diff    (blue_diff),
		.red_diff     (red_diff),
		.chroma_valid (m_axis_tuser),
		.frame_end    (m_axis_tlast)
	);

endmodule

@@ sv/rycc_front.sv @@
// ----------------------------------------------------------------------------
// rycc_front
// Accepts pixels, tracks raster position, keeps the even row in a line store
// and forms the rounded 2x2 channel means of each completed quad.
// ----------------------------------------------------------------------------
module rycc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [12:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rycc_pkg::rgb_t        in_pixel,
	output logic                  push,
	output rycc_pkg::entry_t      push_entry,
	input  logic                  fifo_full
);
	import rycc_pkg::*;

	logic [SizeW-1:0] width_q, height_q;
	logic [ColW-1:0]  col_q, last_col_idx;
	logic [RowW-1:0]  row_q, last_row_idx;
	rgb_t             left_q;
	logic [23:0]      rd_q, prev_rd_q;
	logic [23:0]      line_mem [MaxWidth];

	logic  vld_s1, odd_row_s1, odd_col_s1, chroma_s1, fend_s1;
	rgb_t  pix_s1, left_s1;

	logic  accept, last_col, last_row, odd_row, odd_col;
	rgb_t  p00, p01, p10, p11, mean;
	logic [9:0] sum_r, sum_g, sum_b;

	always_comb begin
		if (width_q == '0) begin
			last_col_idx = '0;
		end else if (width_q > SizeW'(MaxWidth)) begin
			last_col_idx = ColW'(MaxWidth - 1);
		end else begin
			last_col_idx = ColW'(width_q - SizeW'(1));
		end
		if (height_q == '0) begin
			last_row_idx = '0;
		end else if (height_q > SizeW'(MaxHeight)) begin
			last_row_idx = RowW'(MaxHeight - 1);
		end else begin
			last_row_idx = RowW'(height_q - SizeW'(1));
		end
	end

	assign push     = vld_s1 && !fifo_full;
	assign in_ready = !vld_s1 || push;
	assign accept   = in_valid && in_ready;
	assign last_col = col_q >= last_col_idx;
	assign last_row = row_q >= last_row_idx;
	assign odd_row  = row_q[0];
	assign odd_col  = col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_write) begin
			case (cfg_index)
				RegImageWidth:  width_q  <= cfg_data;
				RegImageHeight: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				left_q <= in_pixel;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RowW'(1);
				end else begin
					col_q <= col_q + ColW'(1);
				end
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= in_pixel;
			left_s1    <= left_q;
			odd_row_s1 <= odd_row;
			odd_col_s1 <= odd_col;
			chroma_s1  <= (odd_col || last_col) && (odd_row || last_row);
			fend_s1    <= last_col && last_row;
			prev_rd_q  <= rd_q;
			if (odd_row) begin
				rd_q <= line_mem[col_q];
			end else begin
				line_mem[col_q] <= in_pixel;
			end
		end
	end

	always_comb begin
		p00 = pix_s1;
		p01 = pix_s1;
		p10 = pix_s1;
		p11 = pix_s1;
		case ({odd_row_s1, odd_col_s1})
			2'b11: begin
				p00 = prev_rd_q;
				p01 = rd_q;
				p10 = left_s1;
			end
			2'b10: begin
				p00 = rd_q;
				p01 = rd_q;
			end
			2'b01: begin
				p00 = left_s1;
				p10 = left_s1;
			end
			default: ;
		endcase
		sum_r = 10'(p00.red) + 10'(p01.red) + 10'(p10.red) + 10'(p11.red) + 10'd2;
		sum_g = 10'(p00.green) + 10'(p01.green) + 10'(p10.green) + 10'(p11.green)
			+ 10'd2;
		sum_b = 10'(p00.blue) + 10'(p01.blue) + 10'(p10.blue) + 10'(p11.blue) + 10'd2;
		mean.red   = sum_r[9:2];
		mean.green = sum_g[9:2];
		mean.blue  = sum_b[9:2];
		push_entry.pixel        = pix_s1;
		push_entry.mean         = mean;
		push_entry.chroma_valid = chroma_s1;
		push_entry.frame_end    = fend_s1;
	end

endmodule

@@ sv/rycc_fifo.sv @@
// ----------------------------------------------------------------------------
// rycc_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module rycc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rycc_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output rycc_pkg::entry_t pop_entry
);
	import rycc_pkg::*;

	entry_t            slot_q [FifoDepth];
	logic [FifoAw-1:0] wr_q, rd_q;
	logic [FifoAw:0]   count_q;

	assign full      = count_q == (FifoAw+1)'(FifoDepth);
	assign empty     = count_q == '0;
	assign pop_entry = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FifoAw'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FifoAw'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FifoAw+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FifoAw+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

@@ sv/rycc_back.sv @@
// ----------------------------------------------------------------------------
// rycc_back
// Computes luma and the chroma pair from queued entries, two stages deep.
// ----------------------------------------------------------------------------
module rycc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  rycc_pkg::entry_t pop_entry,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       luma,
	output logic [7:0]       blue_diff,
	output logic [7:0]       red_diff,
	output logic             chroma_valid,
	output logic             frame_end
);
	import rycc_pkg::*;

	localparam logic [24:0] ChromaBias = 25'd8421376;

	logic        adv;
	logic        vld_s1, chroma_s1, fend_s1;
	logic [23:0] y_sum_s1;
	logic [22:0] cb_neg_s1, cr_neg_s1;
	logic [7:0]  ra_s1, ba_s1;
	logic [24:0] cb_sum, cr_sum;

	assign adv = !out_valid || out_ready;
	assign pop = adv && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= !empty;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_sum_s1  <= 24'd19595 * 24'(pop_entry.pixel.red)
				+ 24'd38470 * 24'(pop_entry.pixel.green)
				+ 24'd7471 * 24'(pop_entry.pixel.blue) + 24'd32768;
			cb_neg_s1 <= 23'd11059 * 23'(pop_entry.mean.red)
				+ 23'd21709 * 23'(pop_entry.mean.green);
			cr_neg_s1 <= 23'd27439 * 23'(pop_entry.mean.green)
				+ 23'd5329 * 23'(pop_entry.mean.blue);
			ra_s1     <= pop_entry.mean.red;
			ba_s1     <= pop_entry.mean.blue;
			chroma_s1 <= pop_entry.chroma_valid;
			fend_s1   <= pop_entry.frame_end;
		end
	end

	assign cb_sum = {2'b00, ba_s1, 15'd0} + ChromaBias - 25'(cb_neg_s1);
	assign cr_sum = {2'b00, ra_s1, 15'd0} + ChromaBias - 25'(cr_neg_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			luma         <= y_sum_s1[23:16];
			chroma_valid <= chroma_s1;
			frame_end    <= fend_s1;
			if (chroma_s1) begin
				blue_diff <= cb_sum[24] ? 8'hFF : cb_sum[23:16];
				red_diff  <= cr_sum[24] ? 8'hFF : cr_sum[23:16];
			end else begin
				blue_diff <= '0;
				red_diff  <= '0;
			end
		end
	end

endmodule

@@ dv/tb_rgb_to_ycbcr_420_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_ycbcr_420_converter
// Streams RGB pixels into the converter under random gaps and back-pressure
// on both sides. Each accepted pixel is run through a local model of the
// 4:2:0 conversion: luma, quad averaging, line store, odd-edge replication.
// Each output transaction is checked field by field against the oldest
// prediction. Sizes are changed while idle, including mid-frame changes
// and saturated or zero sizes.
// ----------------------------------------------------------------------------
module tb_rgb_to_ycbcr_420_converter;

	import rycc_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 8;
	localparam int TargetPixels = 440;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] blue_diff;
		logic [7:0] red_diff;
		logic       chroma_valid;
		logic       frame_end;
	} ycc_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = RegImageWidth;
	logic [12:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // red, green, blue
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // luma, blue_diff, red_diff
	logic        m_axis_tuser;        // chroma_valid
	logic        m_axis_tlast;        // frame_end

	rgb_to_ycbcr_420_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// model state
	logic [SizeW-1:0] width_reg = WidthReset;
	logic [SizeW-1:0] height_reg = HeightReset;
	rgb_t             line_mem [MaxWidth];
	rgb_t             left_pixel = '0;
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	rgb_t pixel_q [$];
	ycc_t expected_pixels [$];
	int   pending_pixels = 0;
	int   pixels_queued = 0;
	int   pixels_accepted = 0;
	int   error_count = 0;
	int   cycle_count = 0;

	int send_gap = 0;
	int send_calm = 0;
	int recv_gap = 0;
	int recv_calm = 0;
	int recv_hold = 0;
	bit squeeze_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int mean4(input int a, input int b, input int c, input int d);
		return (a + b + c + d + 2) >>> 2;
	endfunction

	function automatic logic [7:0] sat_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic ycc_t convert_pixel(input rgb_t px);
		int unsigned w, h, c, y;
		logic last_col, last_row, odd_row, odd_col, chroma;
		rgb_t q00, q01, q10;
		int ra, ga, ba, sb, sr;
		ycc_t res;
		w = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > MaxHeight) ? MaxHeight : height_reg);
		c = col_pos;
		last_col = (c >= w - 1);
		last_row = (row_pos >= h - 1);
		odd_row = (row_pos % 2) == 1;
		odd_col = (c % 2) == 1;
		chroma = odd_col || last_col;
		q00 = px;
		q01 = px;
		q10 = px;
		res = '0;
		y = (19595 * int'(px.red) + 38470 * int'(px.green) + 7471 * int'(px.blue)
			+ 32768) >> 16;
		res.luma = y[7:0];
		if (chroma) begin
			if (odd_row) begin
				if (odd_col) begin
					q00 = line_mem[c - 1];
					q01 = line_mem[c];
					q10 = left_pixel;
				end else begin
					q00 = line_mem[c];
					q01 = q00;
				end
			end else if (last_row) begin
				if (odd_col) begin
					q00 = left_pixel;
					q10 = left_pixel;
				end
			end else begin
				chroma = 1'b0;
			end
		end
		if (chroma) begin
			ra = mean4(q00.red, q01.red, q10.red, px.red);
			ga = mean4(q00.green, q01.green, q10.green, px.green);
			ba = mean4(q00.blue, q01.blue, q10.blue, px.blue);
			sb = -11059 * ra - 21709 * ga + 32768 * ba + 32768 + (128 << 16);
			sr = 32768 * ra - 27439 * ga - 5329 * ba + 32768 + (128 << 16);
			res.blue_diff = sat_byte(sb / 65536);
			res.red_diff = sat_byte(sr / 65536);
		end
		res.chroma_valid = chroma;
		res.frame_end = last_col && last_row;
		if (!odd_row)
			line_mem[c] = px;
		left_pixel = px;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : ((row_pos + 1) & 12'hFFF);
		end else begin
			col_pos = (c + 1) & 12'hFFF;
		end
		return res;
	endfunction

	function automatic logic [7:0] random_channel();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return $urandom_range(0, 255);
	endfunction

	function automatic rgb_t make_px(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		rgb_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		return px;
	endfunction

	task automatic queue_pixel(input rgb_t px);
		pixel_q.push_back(px);
		pending_pixels++;
		pixels_queued++;
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			queue_pixel(make_px(random_channel(), random_channel(), random_channel()));
	endtask

	task automatic wait_idle();
		while (pending_pixels != 0 || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_sizes(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= RegImageWidth;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= RegImageHeight;
		cfg_data <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg = w;
		height_reg = h;
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			error_count++;
		end
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
			send_calm <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pixel_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pixel_q.pop_front();
				if (send_calm > 0) begin
					send_calm <= send_calm - 1;
					send_gap <= 0;
				end else begin
					send_gap <= gap_length();
					if ($urandom_range(0, 29) == 0)
						send_calm <= $urandom_range(16, 48);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver; one long hold-off fills the block and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
			recv_calm <= 0;
			recv_hold <= 0;
			squeeze_done <= 1'b0;
		end else if (recv_hold > 0) begin
			m_axis_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else if (!squeeze_done && pixels_accepted >= 150) begin
			m_axis_tready <= 1'b0;
			recv_hold <= 400;
			squeeze_done <= 1'b1;
		end else if (recv_gap > 0) begin
			m_axis_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (recv_calm > 0) begin
				recv_calm <= recv_calm - 1;
			end else begin
				recv_gap <= gap_length();
				if ($urandom_range(0, 29) == 0)
					recv_calm <= $urandom_range(16, 48);
			end
		end
	end

	// predict on every accepted pixel
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_pixels.push_back(convert_pixel(rgb_t'(s_axis_tdata)));
			pending_pixels--;
			pixels_accepted++;
		end
	end

	// check every output transaction
	always @(posedge clk) begin
		ycc_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected transaction tdata=%h tuser=%b tlast=%b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("luma", want.luma, m_axis_tdata[7:0]);
				check_field("blue_diff", want.blue_diff, m_axis_tdata[15:8]);
				check_field("red_diff", want.red_diff, m_axis_tdata[23:16]);
				check_field("chroma_valid", want.chroma_valid, m_axis_tuser);
				check_field("frame_end", want.frame_end, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("rgb_to_ycbcr_420_converter: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes count as one: every pixel is a whole frame
		write_sizes(13'd0, 13'd0);
		queue_pixel(make_px(8'd255, 8'd0, 8'd0));
		queue_pixel(make_px(8'd0, 8'd255, 8'd0));
		queue_pixel(make_px(8'd0, 8'd0, 8'd255));
		wait_idle();

		write_sizes(13'd2, 13'd2);
		for (int i = 0; i < 4; i++)
			queue_pixel(make_px(8'd0, 8'd0, 8'd0));
		for (int i = 0; i < 4; i++)
			queue_pixel(make_px(8'd255, 8'd255, 8'd255));
		wait_idle();

		// odd width and height: replicated column and row
		write_sizes(13'd3, 13'd3);
		send_random(9);
		wait_idle();

		write_sizes(13'd5, 13'd3);
		send_random(45);
		wait_idle();
		write_sizes(13'd1, 13'd7);
		send_random(14);
		wait_idle();
		write_sizes(13'd8, 13'd1);
		send_random(32);
		wait_idle();
		write_sizes(13'd6, 13'd4);
		send_random(72);
		wait_idle();

		// saturated sizes, left mid-row
		write_sizes(13'd8191, 13'd8191);
		send_random(60);
		wait_idle();
		// narrower width ends the current row at once
		write_sizes(13'd7, 13'd8191);
		send_random(22);
		wait_idle();
		// lower height makes the current row the last
		write_sizes(13'd9, 13'd5);
		send_random(9);
		wait_idle();
		write_sizes(13'd4, 13'd6);
		send_random(6);
		wait_idle();
		write_sizes(13'd4, 13'd1);
		send_random(2);
		wait_idle();

		while (pixels_queued < TargetPixels) begin
			int unsigned w, h;
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			write_sizes(w[SizeW-1:0], h[SizeW-1:0]);
			send_random(w * h);
			wait_idle();
		end

		if (error_count == 0)
			$display("rgb_to_ycbcr_420_converter: match");
		else
			$display("rgb_to_ycbcr_420_converter: mismatch");
		$finish;
	end

endmodule
